@@ design/block_padding_appender_core_macros.svh @@
// ----------------------------------------------------------------------------
// Block padding appender assertion macros
// Concurrent check helpers clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_PADDING_APPENDER_CORE_MACROS_SVH
`define BLOCK_PADDING_APPENDER_CORE_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge out of reset
`define BPA_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("bpa assertion failed");
// consequent must hold in the cycle after the antecedent
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bpa assertion failed");
`else
`define BPA_ASSERT(label, prop)
`define BPA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Block padding appender package
// Shared widths, constants and the structs passed between the submodules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int SIZE_W = 9;
    localparam int POS_W  = 8;
    localparam int BYTE_W = 8;

    // largest pad and the marker used by a full 256-byte pad
    localparam logic [SIZE_W-1:0] FULL_BLOCK = 9'd256;
    localparam logic [BYTE_W-1:0] MARK_BYTE  = 8'hff;

    // item kind carried on tuser
    typedef enum logic {
        CMD_MESSAGE = 1'b0,
        CMD_PAD     = 1'b1
    } cmd_t;

    // register indexes, one 32-bit word each
    typedef enum logic [1:0] {
        REG_BLOCK_SIZE  = 2'd0,
        REG_RANDOM_FILL = 2'd1,
        REG_FILL_BYTE   = 2'd2,
        REG_SPARE       = 2'd3
    } reg_index_t;

    // live configuration
    typedef struct packed {
        logic [SIZE_W-1:0] block_size;
        logic              random_fill;
        logic [BYTE_W-1:0] fill_byte;
    } cfg_t;

    // result produced by one accepted item
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } result_t;

endpackage

@@ design/bpa_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Block padding appender configuration registers
// APB register file holding block size, fill mode and fixed fill byte.
// ----------------------------------------------------------------------------
module bpa_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bpa_pkg::cfg_t cfg
);

    bpa_pkg::cfg_t       cfg_reg;
    bpa_pkg::reg_index_t index;
    logic                wr_en;

    assign index  = bpa_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_size  <= 9'd16;
            cfg_reg.random_fill <= 1'b0;
            cfg_reg.fill_byte   <= 8'd0;
        end else if (wr_en) begin
            unique case (index)
                bpa_pkg::REG_BLOCK_SIZE:  cfg_reg.block_size  <= pwdata[8:0];
                bpa_pkg::REG_RANDOM_FILL: cfg_reg.random_fill <= pwdata[0];
                bpa_pkg::REG_FILL_BYTE:   cfg_reg.fill_byte   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = 32'd0;
        unique case (index)
            bpa_pkg::REG_BLOCK_SIZE:  prdata = {23'd0, cfg_reg.block_size};
            bpa_pkg::REG_RANDOM_FILL: prdata = {31'd0, cfg_reg.random_fill};
            bpa_pkg::REG_FILL_BYTE:   prdata = {24'd0, cfg_reg.fill_byte};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

@@ design/bpa_pad_engine.sv @@
// ----------------------------------------------------------------------------
// Block padding appender pad engine
// Block position counter, pad length tracking and result byte selection.
// ----------------------------------------------------------------------------
`include "block_padding_appender_core_macros.svh"

module bpa_pad_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_fire,
    input  logic             cmd,
    input  logic [7:0]       data_byte,
    input  logic [7:0]       random_byte,
    input  bpa_pkg::cfg_t    cfg,
    output bpa_pkg::result_t result
);

    logic [bpa_pkg::POS_W-1:0]  pos_reg,    pos_next;
    logic                       active_reg, active_next;
    logic [bpa_pkg::SIZE_W-1:0] total_reg,  total_next;
    logic [bpa_pkg::SIZE_W-1:0] rem_reg,    rem_next;

    logic [bpa_pkg::SIZE_W-1:0] size;
    logic [bpa_pkg::SIZE_W-1:0] pos_ext;
    logic [bpa_pkg::SIZE_W-1:0] pos_inc;
    logic [bpa_pkg::SIZE_W-1:0] start_total;
    logic [bpa_pkg::SIZE_W-1:0] eff_total;
    logic [bpa_pkg::SIZE_W-1:0] eff_rem;
    logic [bpa_pkg::BYTE_W-1:0] filler;
    logic                       full_pad;

    // saturated block size and the pad length a new pad would take
    assign size        = (cfg.block_size > bpa_pkg::FULL_BLOCK) ? bpa_pkg::FULL_BLOCK
                                                                 : cfg.block_size;
    assign pos_ext     = {1'b0, pos_reg};
    assign pos_inc     = pos_ext + 9'd1;
    assign start_total = (pos_ext < size) ? (size - pos_ext) : size;
    assign eff_total   = active_reg ? total_reg : start_total;
    assign eff_rem     = active_reg ? rem_reg : start_total;
    assign full_pad    = (eff_total == bpa_pkg::FULL_BLOCK);
    assign filler      = cfg.random_fill ? random_byte : cfg.fill_byte;

    // next state and result for the item on the input
    always_comb begin
        pos_next        = pos_reg;
        active_next     = active_reg;
        total_next      = total_reg;
        rem_next        = rem_reg;
        result.valid    = 1'b0;
        result.out_byte = data_byte;
        result.out_last = 1'b0;
        if (cmd == bpa_pkg::CMD_MESSAGE) begin
            if (!active_reg) begin
                result.valid = 1'b1;
                if ((size == 9'd0) || (pos_inc >= size)) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_inc[bpa_pkg::POS_W-1:0];
                end
            end
        end else if (active_reg || (size != 9'd0)) begin
            result.valid = 1'b1;
            total_next   = eff_total;
            if (eff_rem == 9'd1) begin
                // final byte carries the pad length, or the marker for a full 256-byte pad
                result.out_byte = full_pad ? bpa_pkg::MARK_BYTE : eff_total[7:0];
                result.out_last = 1'b1;
                active_next     = 1'b0;
                rem_next        = '0;
                pos_next        = '0;
            end else begin
                result.out_byte = ((eff_rem == 9'd2) && full_pad) ? bpa_pkg::MARK_BYTE
                                                                   : filler;
                active_next     = 1'b1;
                rem_next        = eff_rem - 9'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            active_reg <= 1'b0;
            total_reg  <= '0;
            rem_reg    <= '0;
        end else if (item_fire) begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
            total_reg  <= total_next;
            rem_reg    <= rem_next;
        end
    end

    // pad bookkeeping checks
    `BPA_ASSERT(a_rem_within_total, !active_reg || ((rem_reg != 9'd0) && (rem_reg <= total_reg)))
    `BPA_ASSERT(a_idle_rem_clear, active_reg || (rem_reg == 9'd0))
    `BPA_ASSERT_NEXT(a_last_clears, item_fire && result.valid && result.out_last,
                     !active_reg && (pos_reg == 8'd0))

endmodule

@@ design/bpa_out_reg.sv @@
// ----------------------------------------------------------------------------
// Block padding appender output register
// Holds one result for the master side and frees the input while it drains.
// ----------------------------------------------------------------------------
`include "block_padding_appender_core_macros.svh"

module bpa_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bpa_pkg::result_t result,
    input  logic             m_tready,
    output logic             take_ready,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    // new item fits when the slot is empty or being drained this cycle
    assign take_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = result.valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load && result.valid) begin
            data_reg <= result.out_byte;
            last_reg <= result.out_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // a produced result always shows up next cycle
    `BPA_ASSERT_NEXT(a_result_shown, load && result.valid, m_tvalid)
    `BPA_ASSERT_NEXT(a_empty_stays, !load && !m_tvalid, !m_tvalid)

endmodule

@@ design/block_padding_appender_core.sv @@
// ----------------------------------------------------------------------------
// Block padding appender core
// Appends ISO 10126 style padding (random or fixed fill) to a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte transfer per clock unless m_tready back-pressure stalls it,
// and gives at most one result per transfer, in the cycle after acceptance.
// Unstalled throughput is one byte per cycle: the pad length is 9-bit subtract
// and compare logic ahead of the output register, which lets a new transfer
// in whenever it is empty or being drained. Message bytes (tuser 0) pass
// through; pad steps (tuser 1) emit pad bytes, the final one carrying tlast.
// Message bytes during padding and pad steps with nothing to pad produce no output transfer.
module block_padding_appender_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] random_byte
    input  logic        s_tuser,   // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    bpa_pkg::cfg_t    cfg;
    bpa_pkg::result_t result;
    logic             item_fire;

    assign item_fire = s_tvalid && s_tready;

    bpa_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpa_pad_engine u_pad_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_fire   (item_fire),
        .cmd         (s_tuser),
        .data_byte   (s_tdata[7:0]),
        .random_byte (s_tdata[15:8]),
        .cfg         (cfg),
        .result      (result)
    );

    bpa_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (item_fire),
        .result     (result),
        .m_tready   (m_tready),
        .take_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
